// ===== sv/display_mode_control_registers_assert.svh =====
// assertion macros for the display-mode control port block
// used by the checker file; no other dependencies
`ifndef DISPLAY_MODE_CONTROL_REGISTERS_ASSERT_SVH
`define DISPLAY_MODE_CONTROL_REGISTERS_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define DMCR_ASSERT_NOW(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("dmcr check failed");

// condition holds in the cycle after the trigger
`define DMCR_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("dmcr check failed");

`endif

// ===== sv/dmcr_pkg.sv =====
// types and constants for the display-mode control port block
// no dependencies
package dmcr_pkg;

   localparam int CmdW      = 3;
   localparam int OffsetW   = 4;
   localparam int ByteW     = 8;
   localparam int ScanW     = 5;
   localparam int VmodeW    = 5;
   localparam int FlagsW    = 6;
   localparam int CsrIdxW   = 2;
   localparam int ScanDepth = 6;
   localparam int ScanIdxW  = 3;

   // access codes
   localparam logic [CmdW-1:0] CMD_CRTC_WR  = 3'd0;
   localparam logic [CmdW-1:0] CMD_CRTC_RD  = 3'd1;
   localparam logic [CmdW-1:0] CMD_MODE_A   = 3'd2;
   localparam logic [CmdW-1:0] CMD_MODE_B   = 3'd3;
   localparam logic [CmdW-1:0] CMD_SEL_WR   = 3'd4;
   localparam logic [CmdW-1:0] CMD_STAT_RD  = 3'd5;

   // crtc register numbers above the scanline group
   localparam logic [ScanIdxW-1:0] REG_MODE = 3'd6;
   localparam logic [ScanIdxW-1:0] REG_TILE = 3'd7;

   // configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_GRCG     = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_EGC      = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_COLOR16  = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_COLOR256 = 2'd3;

   // mode command A bytes
   localparam logic [ByteW-1:0] A_ANALOG_OFF = 8'h00;
   localparam logic [ByteW-1:0] A_ANALOG_ON  = 8'h01;
   localparam logic [ByteW-1:0] A_EGC_OFF    = 8'h04;
   localparam logic [ByteW-1:0] A_EGC_ON     = 8'h05;
   localparam logic [ByteW-1:0] A_LOCK       = 8'h06;
   localparam logic [ByteW-1:0] A_UNLOCK     = 8'h07;
   localparam logic [ByteW-1:0] A_VGA_OFF    = 8'h20;
   localparam logic [ByteW-1:0] A_VGA_ON     = 8'h21;
   localparam logic [ByteW-1:0] A_CRT_ON     = 8'h40;
   localparam logic [ByteW-1:0] A_CRT_OFF    = 8'h41;
   localparam logic [ByteW-1:0] A_BND_OFF    = 8'h68;
   localparam logic [ByteW-1:0] A_BND_ON     = 8'h69;
   localparam logic [ByteW-1:0] A_CLK1_OFF   = 8'h82;
   localparam logic [ByteW-1:0] A_CLK1_ON    = 8'h83;
   localparam logic [ByteW-1:0] A_CLK2_OFF   = 8'h84;
   localparam logic [ByteW-1:0] A_CLK2_ON    = 8'h85;

   // mode command B bytes
   localparam logic [ByteW-1:0] B_ATTR_OFF   = 8'h00;
   localparam logic [ByteW-1:0] B_ATTR_ON    = 8'h01;
   localparam logic [ByteW-1:0] B_40COL_OFF  = 8'h04;
   localparam logic [ByteW-1:0] B_40COL_ON   = 8'h05;
   localparam logic [ByteW-1:0] B_ODD_OFF    = 8'h08;
   localparam logic [ByteW-1:0] B_ODD_ON     = 8'h09;
   localparam logic [ByteW-1:0] B_DISP_OFF   = 8'h0E;
   localparam logic [ByteW-1:0] B_DISP_ON    = 8'h0F;

   // status select codes
   localparam logic [ByteW-1:0] SEL_ONE     = 8'h01;
   localparam logic [ByteW-1:0] SEL_ODD     = 8'h02;
   localparam logic [ByteW-1:0] SEL_DISP    = 8'h03;
   localparam logic [ByteW-1:0] SEL_ANALOG  = 8'h04;

   localparam logic [ByteW-1:0] READ_NONE   = 8'hFF;
   localparam logic [ByteW-1:0] FAST_BIT    = 8'h02;

   // bit positions
   localparam int OP_ANALOG = 2;
   localparam int OP_EGC    = 3;
   localparam int OP_VGA    = 4;
   localparam int FL_ATTR4  = 0;
   localparam int FL_40COL  = 1;
   localparam int FL_ODD    = 2;
   localparam int FL_DISP   = 3;
   localparam int FL_CRT    = 4;
   localparam int FL_256KB  = 5;

   typedef struct packed {
      logic [CmdW-1:0]    cmd;
      logic [OffsetW-1:0] port_offset;
      logic [ByteW-1:0]   data;
   } req_item_type;

   typedef struct packed {
      logic [ByteW-1:0]  read_data;
      logic [VmodeW-1:0] vram_mode;
      logic [FlagsW-1:0] display_flags;
      logic              analog_active;
      logic              fast_clock;
      logic              remap_pulse;
   } rsp_item_type;

   typedef struct packed {
      logic grcg_present;
      logic egc_present;
      logic color16_present;
      logic color256_present;
   } cfg_type;

endpackage

// ===== sv/dmcr_if.sv =====
// channel interfaces: access requests, results and configuration writes
// depends on dmcr_pkg
interface dmcr_req_if
   import dmcr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CmdW-1:0]    cmd;
   logic [OffsetW-1:0] port_offset;
   logic [ByteW-1:0]   data;

   modport source (output valid, cmd, port_offset, data, input ready);
   modport sink   (input valid, cmd, port_offset, data, output ready);
endinterface

interface dmcr_rsp_if
   import dmcr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [ByteW-1:0]  read_data;
   logic [VmodeW-1:0] vram_mode;
   logic [FlagsW-1:0] display_flags;
   logic              analog_active;
   logic              fast_clock;
   logic              remap_pulse;

   modport source (output valid, read_data, vram_mode, display_flags, analog_active,
                   fast_clock, remap_pulse, input ready);
   modport sink   (input valid, read_data, vram_mode, display_flags, analog_active,
                   fast_clock, remap_pulse, output ready);
endinterface

interface dmcr_csr_if
   import dmcr_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CsrIdxW-1:0] index;
   logic               data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dmcr_in_stage.sv =====
// input register for access items
// depends on dmcr_pkg and dmcr_req_if
module dmcr_in_stage
   import dmcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   dmcr_req_if.sink     req,
   input  logic         advance,
   output logic         item_valid,
   output req_item_type item
);
   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;
   assign valid_in  = take || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{cmd: req.cmd, port_offset: req.port_offset, data: req.data};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// ===== sv/dmcr_core.sv =====
// mode state registers, config registers and the per-item update logic
// depends on dmcr_pkg
module dmcr_core
   import dmcr_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  req_item_type       item,
   input  logic               csr_write,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic               csr_data,
   output rsp_item_type       result
);
   // tile data, tile counter and the full mode byte are never read back,
   // so only the raster-op bits of a mode write are kept
   logic [ScanW-1:0]  scan_ff [ScanDepth];
   logic [VmodeW-1:0] vop_ff, vop_in;
   logic              unlock_ff, unlock_in;
   logic              clk1_ff, clk1_in;
   logic              clk2_ff, clk2_in;
   logic [FlagsW-1:0] flags_ff, flags_in;
   logic [ByteW-1:0]  sel_ff, sel_in;
   cfg_type           cfg_ff, cfg_in;

   logic [ScanIdxW-1:0] reg_sel;
   logic                scan_hit;
   logic                scan_we;
   logic [ByteW-1:0]    rd;
   logic                remap;
   logic                fast;

   assign reg_sel  = item.port_offset[3:1];
   assign scan_hit = reg_sel < ScanIdxW'(ScanDepth);
   assign scan_we  = fire && item.cmd == CMD_CRTC_WR && scan_hit;

   always_comb begin
      vop_in    = vop_ff;
      unlock_in = unlock_ff;
      clk1_in   = clk1_ff;
      clk2_in   = clk2_ff;
      flags_in  = flags_ff;
      sel_in    = sel_ff;
      rd        = '0;
      remap     = 1'b0;
      case (item.cmd)
         CMD_CRTC_WR: begin
            if (reg_sel == REG_MODE && cfg_ff.grcg_present) begin
               vop_in[1:0] = item.data[7:6];
            end
         end
         CMD_CRTC_RD: begin
            rd = scan_hit ? ByteW'(scan_ff[reg_sel]) : READ_NONE;
         end
         CMD_MODE_A: begin
            case (item.data)
               A_ANALOG_OFF: begin
                  vop_in[OP_ANALOG] = 1'b0;
                  remap = 1'b1;
               end
               A_ANALOG_ON: begin
                  if (cfg_ff.color16_present) begin
                     vop_in[OP_ANALOG] = 1'b1;
                     remap = 1'b1;
                  end
               end
               A_EGC_OFF: begin
                  if (unlock_ff) vop_in[OP_EGC] = 1'b0;
               end
               A_EGC_ON: begin
                  if (unlock_ff && cfg_ff.egc_present) vop_in[OP_EGC] = 1'b1;
               end
               A_LOCK:   unlock_in = 1'b0;
               A_UNLOCK: unlock_in = 1'b1;
               A_VGA_OFF: begin
                  if (unlock_ff && cfg_ff.egc_present) begin
                     vop_in[OP_VGA] = 1'b0;
                     remap = 1'b1;
                  end
               end
               A_VGA_ON: begin
                  if (unlock_ff && cfg_ff.egc_present && cfg_ff.color256_present) begin
                     vop_in[OP_VGA] = 1'b1;
                     remap = 1'b1;
                  end
               end
               A_CRT_ON, A_CRT_OFF: flags_in[FL_CRT] = !item.data[0];
               A_BND_OFF, A_BND_ON: begin
                  flags_in[FL_256KB] = item.data[0];
                  remap = 1'b1;
               end
               A_CLK1_OFF, A_CLK1_ON: clk1_in = item.data[0];
               A_CLK2_OFF, A_CLK2_ON: clk2_in = item.data[0];
               default: ;
            endcase
         end
         CMD_MODE_B: begin
            case (item.data)
               B_ATTR_OFF, B_ATTR_ON:   flags_in[FL_ATTR4] = item.data[0];
               B_40COL_OFF, B_40COL_ON: flags_in[FL_40COL] = item.data[0];
               B_ODD_OFF, B_ODD_ON:     flags_in[FL_ODD]   = item.data[0];
               B_DISP_OFF, B_DISP_ON:   flags_in[FL_DISP]  = item.data[0];
               default: ;
            endcase
         end
         CMD_SEL_WR: sel_in = item.data;
         CMD_STAT_RD: begin
            case (sel_ff)
               SEL_ONE:    rd = 8'h01;
               SEL_ODD:    rd = ByteW'(flags_ff[FL_ODD]);
               SEL_DISP:   rd = ByteW'(flags_ff[FL_DISP]);
               SEL_ANALOG: rd = ByteW'(vop_ff[OP_ANALOG]);
               default:    rd = READ_NONE;
            endcase
         end
         default: ;
      endcase
      fast = clk1_in && clk2_in;
      if (item.cmd == CMD_STAT_RD && fast) rd = rd | FAST_BIT;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_GRCG:     cfg_in.grcg_present     = csr_data;
            CSR_EGC:      cfg_in.egc_present      = csr_data;
            CSR_COLOR16:  cfg_in.color16_present  = csr_data;
            CSR_COLOR256: cfg_in.color256_present = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vop_ff    <= '0;
         unlock_ff <= 1'b0;
         clk1_ff   <= 1'b0;
         clk2_ff   <= 1'b0;
         flags_ff  <= '0;
         sel_ff    <= '0;
         cfg_ff    <= '{grcg_present: 1'b1, egc_present: 1'b1,
                        color16_present: 1'b1, color256_present: 1'b1};
      end else begin
         cfg_ff <= cfg_in;
         if (fire) begin
            vop_ff    <= vop_in;
            unlock_ff <= unlock_in;
            clk1_ff   <= clk1_in;
            clk2_ff   <= clk2_in;
            flags_ff  <= flags_in;
            sel_ff    <= sel_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ScanDepth; i++) scan_ff[i] <= '0;
      end else if (scan_we) begin
         scan_ff[reg_sel] <= item.data[ScanW-1:0];
      end
   end

   assign result = '{read_data:     rd,
                     vram_mode:     vop_in,
                     display_flags: flags_in,
                     analog_active: vop_in[OP_ANALOG] || vop_in[OP_VGA],
                     fast_clock:    fast,
                     remap_pulse:   remap};
endmodule

// ===== sv/dmcr_out_stage.sv =====
// result register driving the response channel
// depends on dmcr_pkg and dmcr_rsp_if
module dmcr_out_stage
   import dmcr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type item,
   output logic         can_load,
   dmcr_rsp_if.source   rsp
);
   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   assign can_load = !valid_ff || rsp.ready;
   assign valid_in = load || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item;
      end
   end

   assign rsp.valid         = valid_ff;
   assign rsp.read_data     = item_ff.read_data;
   assign rsp.vram_mode     = item_ff.vram_mode;
   assign rsp.display_flags = item_ff.display_flags;
   assign rsp.analog_active = item_ff.analog_active;
   assign rsp.fast_clock    = item_ff.fast_clock;
   assign rsp.remap_pulse   = item_ff.remap_pulse;
endmodule

// ===== sv/display_mode_control_registers.sv =====
// top level of the display-mode control port block
// depends on dmcr_pkg, the dmcr interfaces, dmcr_in_stage, dmcr_core, dmcr_out_stage
//
//   channel   direction  handshake     carries
//   req_ch    in         valid/ready   cmd, port_offset, data
//   rsp_ch    out        valid/ready   read_data, vram_mode, display_flags, flags
//   csr_ch    in         valid/ready   index, data (feature enables)
//
// one item per cycle sustained while rsp_ch is ready; each item passes through the
// input register and then the result register before it appears at rsp_ch;
// the mode state updates as the item leaves the input register, so reads
// see all earlier accesses; synchronous reset clears state, enables go to 1
// a stalled rsp_ch holds the result and the input register; req_ch stalls
// only while both registers are full; csr_ch is always ready
module display_mode_control_registers
   import dmcr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   dmcr_req_if.sink    req_ch,
   dmcr_rsp_if.source  rsp_ch,
   dmcr_csr_if.sink    csr_ch
);
   logic         s1_valid;
   req_item_type s1_item;
   logic         advance;
   logic         fire;
   rsp_item_type result;

   // item moves from the input register into the result register
   assign fire = s1_valid && advance;

   // configuration is plain flops, taken every cycle
   assign csr_ch.ready = 1'b1;

   dmcr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .advance    (advance),
      .item_valid (s1_valid),
      .item       (s1_item)
   );

   dmcr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item      (s1_item),
      .csr_write (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .result    (result)
   );

   dmcr_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (fire),
      .item     (result),
      .can_load (advance),
      .rsp      (rsp_ch)
   );
endmodule

// ===== sv/dmcr_checker.sv =====
// port-level checks for the display-mode control port block, bound to the top
// depends on display_mode_control_registers_assert.svh
`include "display_mode_control_registers_assert.svh"

module dmcr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic [4:0] rsp_vram_mode,
   input logic [5:0] rsp_display_flags,
   input logic       rsp_analog_active
);
   // a held result keeps its payload
   `DMCR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_read_data) && $stable(rsp_vram_mode) && $stable(rsp_display_flags))

   // input only backs up when a result is waiting
   `DMCR_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid)

   // analog flag follows the mode bits
   `DMCR_ASSERT_NOW(a_analog, clock, reset, rsp_valid, rsp_analog_active == (rsp_vram_mode[2] || rsp_vram_mode[4]))

   // nothing comes out right after reset
   `DMCR_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid)
endmodule

bind display_mode_control_registers dmcr_checker u_dmcr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_read_data     (rsp_ch.read_data),
   .rsp_vram_mode     (rsp_ch.vram_mode),
   .rsp_display_flags (rsp_ch.display_flags),
   .rsp_analog_active (rsp_ch.analog_active)
);
